// ----- rtl/sorted_linked_table_top_macros.svh -----
// Assertion helpers used by the RTL file slt_dp
`ifndef SORTED_LINKED_TABLE_TOP_MACROS_SVH
`define SORTED_LINKED_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/slt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_RANK   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_LAST   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NAME_LONG = 3'd2,
      ST_RANK      = 3'd3,
      ST_NO_LAST   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      RD_SLOT = 3'd0,
      RD_HEAD = 3'd1,
      RD_NEXT = 3'd2,
      RD_LINK = 3'd3,
      RD_LAST = 3'd4
   } rd_src_type;

   typedef struct packed {
      logic       capture;
      logic       load_head;
      logic       take_slot;
      logic       wr_slot_link;
      logic       wr_cur_link;
      logic       set_used_head;
      logic       advance;
      logic       sweep_init;
      logic       sweep_step;
      rd_src_type rd_src;
      logic       respond;
      logic       with_data;
      status_type status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   mode_bad;
      logic   name_long;
      logic   free_empty;
      logic   head_empty;
      logic   rank_zero;
      logic   last_valid;
      logic   t_less;
      logic   link_null;
      logic   k_hit;
      logic   at_head;
      logic   sweep_last;
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/sorted_linked_table_top.sv -----
// Sorted linked table: one ascending list per mode, each over its own fixed entry pool.
// Request channel: drive req_* and raise start; the transaction is taken on
// the clock edge where start is high and busy is low. busy then stays high
// until the result has been produced.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_status,
// rsp_time_out and rsp_name_out; the receiver cannot stall, so it must take
// the result in that cycle.
// Record inserts directly into an empty list or ahead of the head, otherwise
// walks the list to its insertion point; fetch by rank walks from the head
// to the wanted entry or to the end of the list; fetch last reads the last
// record directly; rejected requests answer from the check state; clear
// rewrites every link of every mode, one link rewritten per cycle.
// The walks follow one link per cycle through the single read port of the
// link/time/name memories; one transaction is in flight at a time.
// After reset the link memory is swept, one entry per cycle, over all
// MODES * ENTRIES entries with busy high before the first request is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_linked_table_top
   import slt_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int MODES      = 4,
   parameter int NAME_BYTES = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_opcode,
   input  wire  [1:0]  req_mode,
   input  wire  [31:0] req_time_value,
   input  wire  [63:0] req_name_chars,
   input  wire  [7:0]  req_name_length,
   input  wire  [7:0]  req_rank_wanted,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_time_out,
   output logic [63:0] rsp_name_out
);

   cmd_type cmd;
   sts_type sts;

   slt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   slt_dp #(
      .ENTRIES    (ENTRIES),
      .MODES      (MODES),
      .NAME_BYTES (NAME_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_mode        (req_mode),
      .req_time_value  (req_time_value),
      .req_name_chars  (req_name_chars),
      .req_name_length (req_name_length),
      .req_rank_wanted (req_rank_wanted),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_time_out    (rsp_time_out),
      .rsp_name_out    (rsp_name_out)
   );

endmodule

`default_nettype wire

// ----- rtl/slt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slt_ctrl
   import slt_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      S_INIT  = 10'b00_0000_0001,
      S_IDLE  = 10'b00_0000_0010,
      S_CHECK = 10'b00_0000_0100,
      S_TAKE  = 10'b00_0000_1000,
      S_WALK  = 10'b00_0001_0000,
      S_INS1  = 10'b00_0010_0000,
      S_INS2  = 10'b00_0100_0000,
      S_FWALK = 10'b00_1000_0000,
      S_LAST  = 10'b01_0000_0000,
      S_CLEAR = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_src = RD_LINK;
      cmd.status = ST_OK;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            case (sts.op)
               OP_RECORD: begin
                  if (sts.mode_bad || sts.free_empty || sts.name_long) begin
                     cmd.respond = 1'b1;
                     cmd.status  = (!sts.mode_bad && sts.name_long) ? ST_NAME_LONG
                                                                     : ST_FULL;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.load_head = 1'b1;
                     cmd.rd_src    = RD_SLOT;
                     state_in      = S_TAKE;
                  end
               end
               OP_RANK: begin
                  if (sts.mode_bad || sts.rank_zero || sts.head_empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_RANK;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.load_head = 1'b1;
                     cmd.rd_src    = RD_HEAD;
                     state_in      = S_FWALK;
                  end
               end
               OP_CLEAR: begin
                  cmd.sweep_init = 1'b1;
                  state_in       = S_CLEAR;
               end
               default: begin
                  if (!sts.last_valid) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_NO_LAST;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.rd_src = RD_LAST;
                     state_in   = S_LAST;
                  end
               end
            endcase
         end
         S_TAKE: begin
            cmd.take_slot = 1'b1;
            if (sts.head_empty) begin
               cmd.wr_slot_link  = 1'b1;
               cmd.set_used_head = 1'b1;
               cmd.respond       = 1'b1;
               state_in          = S_IDLE;
            end else begin
               cmd.rd_src = RD_NEXT;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.t_less) begin
               cmd.wr_slot_link = 1'b1;
               if (sts.at_head) begin
                  cmd.set_used_head = 1'b1;
                  cmd.respond       = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  state_in = S_INS2;
               end
            end else begin
               cmd.advance = 1'b1;
               if (sts.link_null) state_in = S_INS1;
            end
         end
         S_INS1: begin
            cmd.wr_slot_link = 1'b1;
            state_in         = S_INS2;
         end
         S_INS2: begin
            cmd.wr_cur_link = 1'b1;
            cmd.respond     = 1'b1;
            state_in        = S_IDLE;
         end
         S_FWALK: begin
            if (sts.k_hit) begin
               cmd.respond   = 1'b1;
               cmd.with_data = 1'b1;
               state_in      = S_IDLE;
            end else if (sts.link_null) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_RANK;
               state_in    = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_LAST: begin
            cmd.respond   = 1'b1;
            cmd.with_data = 1'b1;
            state_in      = S_IDLE;
         end
         S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/slt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_linked_table_top_macros.svh"

module slt_dp
   import slt_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int MODES      = 4,
   parameter int NAME_BYTES = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  wire  [1:0]  req_opcode,
   input  wire  [1:0]  req_mode,
   input  wire  [31:0] req_time_value,
   input  wire  [63:0] req_name_chars,
   input  wire  [7:0]  req_name_length,
   input  wire  [7:0]  req_rank_wanted,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_time_out,
   output logic [63:0] rsp_name_out
);

   localparam int LW    = $clog2(ENTRIES + 1);
   localparam int IW    = $clog2(ENTRIES);
   localparam int DEPTH = MODES * ENTRIES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW    = (MODES > 1) ? $clog2(MODES) : 1;
   localparam int NW    = 8 * NAME_BYTES;
   localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

   // request
   op_type      op_ff;
   logic [1:0]  mode_ff;
   logic [31:0] time_ff;
   logic [63:0] name_ff;
   logic [7:0]  len_ff;
   logic [7:0]  rank_ff;

   // list walk
   logic [IW-1:0] slot_ff;
   logic [LW-1:0] n_ff;
   logic [IW-1:0] cur_ff;
   logic          at_head_ff;
   logic [8:0]    k_ff;

   logic [LW-1:0] free_head_ff [MODES];
   logic [LW-1:0] used_head_ff [MODES];
   logic          last_valid_ff;
   logic [AW-1:0] last_addr_ff;

   logic [AW-1:0] sw_addr_ff;
   logic [IW-1:0] sw_slot_ff;

   // memories
   logic [LW-1:0] link_mem [DEPTH];
   logic [31:0]   time_mem [DEPTH];
   logic [NW-1:0] name_mem [DEPTH];
   logic [LW-1:0] rd_link_ff;
   logic [31:0]   rd_time_ff;
   logic [NW-1:0] rd_name_ff;

   logic          rsp_strobe_ff;
   status_type    rsp_status_ff;
   logic [31:0]   rsp_time_ff;
   logic [63:0]   rsp_name_ff;

   logic [MW-1:0] mode_idx;
   logic [LW-1:0] free_head_cur;
   logic [LW-1:0] used_head_cur;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] slot_addr_cur;
   logic          link_we;
   logic [AW-1:0] link_waddr;
   logic [LW-1:0] link_wdata;
   logic [NW-1:0] name_kept;

   function automatic logic [AW-1:0] make_addr(input logic [MW-1:0] m,
                                                input logic [IW-1:0] s);
      make_addr = AW'(AW'(m) * AW'(ENTRIES)) + AW'(s);
   endfunction

   assign mode_idx      = MW'(mode_ff);
   assign free_head_cur = free_head_ff[mode_idx];
   assign used_head_cur = used_head_ff[mode_idx];
   assign slot_addr_cur = make_addr(mode_idx, slot_ff);

   always_comb begin
      for (int b = 0; b < NAME_BYTES; b++) begin
         name_kept[8*b +: 8] = (8'(b) < len_ff) ? name_ff[8*b +: 8] : 8'd0;
      end
   end

   always_comb begin
      case (cmd.rd_src)
         RD_SLOT: rd_addr = make_addr(mode_idx, IW'(free_head_cur));
         RD_HEAD: rd_addr = make_addr(mode_idx, IW'(used_head_cur));
         RD_NEXT: rd_addr = make_addr(mode_idx, IW'(n_ff));
         RD_LAST: rd_addr = last_addr_ff;
         default: rd_addr = make_addr(mode_idx, IW'(rd_link_ff));
      endcase
   end

   always_comb begin
      link_we    = 1'b0;
      link_waddr = slot_addr_cur;
      link_wdata = n_ff;
      if (cmd.sweep_step) begin
         link_we    = 1'b1;
         link_waddr = sw_addr_ff;
         link_wdata = (sw_slot_ff == IW'(ENTRIES - 1)) ? NULL_LINK
                                                       : LW'(sw_slot_ff) + LW'(1);
      end else if (cmd.wr_slot_link) begin
         link_we = 1'b1;
      end else if (cmd.wr_cur_link) begin
         link_we    = 1'b1;
         link_waddr = make_addr(mode_idx, cur_ff);
         link_wdata = LW'(slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      rd_link_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_slot) begin
         time_mem[slot_addr_cur] <= time_ff;
         name_mem[slot_addr_cur] <= name_kept;
      end
      rd_time_ff <= time_mem[rd_addr];
      rd_name_ff <= name_mem[rd_addr];
   end

   // request capture, walk pointers and response data
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_opcode);
         mode_ff <= req_mode;
         time_ff <= req_time_value;
         name_ff <= req_name_chars;
         len_ff  <= req_name_length;
         rank_ff <= req_rank_wanted;
      end
      if (cmd.load_head) begin
         n_ff       <= used_head_cur;
         slot_ff    <= IW'(free_head_cur);
         at_head_ff <= 1'b1;
         k_ff       <= 9'd1;
      end else if (cmd.advance) begin
         cur_ff     <= IW'(n_ff);
         n_ff       <= rd_link_ff;
         at_head_ff <= 1'b0;
         k_ff       <= k_ff + 9'd1;
      end
      rsp_status_ff <= cmd.status;
      rsp_time_ff   <= cmd.with_data ? rd_time_ff : 32'd0;
      rsp_name_ff   <= cmd.with_data ? 64'(rd_name_ff) : 64'd0;
   end

   // list heads, last record and sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MODES; i++) begin
            free_head_ff[i] <= '0;
            used_head_ff[i] <= NULL_LINK;
         end
         last_valid_ff <= 1'b0;
         last_addr_ff  <= '0;
         sw_addr_ff    <= '0;
         sw_slot_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
         if (cmd.sweep_init) begin
            for (int i = 0; i < MODES; i++) begin
               free_head_ff[i] <= '0;
               used_head_ff[i] <= NULL_LINK;
            end
            sw_addr_ff <= '0;
            sw_slot_ff <= '0;
         end else if (cmd.sweep_step) begin
            sw_addr_ff <= (sw_addr_ff == AW'(DEPTH - 1)) ? '0 : sw_addr_ff + AW'(1);
            sw_slot_ff <= (sw_slot_ff == IW'(ENTRIES - 1)) ? '0 : sw_slot_ff + IW'(1);
         end
         if (cmd.take_slot) begin
            free_head_ff[mode_idx] <= rd_link_ff;
            last_valid_ff          <= 1'b1;
            last_addr_ff           <= slot_addr_cur;
         end
         if (cmd.set_used_head) used_head_ff[mode_idx] <= LW'(slot_ff);
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.mode_bad   = (32'(mode_ff) >= MODES);
      sts.name_long  = (len_ff > 8'(NAME_BYTES));
      sts.free_empty = (free_head_cur >= NULL_LINK);
      sts.head_empty = (used_head_cur >= NULL_LINK);
      sts.rank_zero  = (rank_ff == 8'd0);
      sts.last_valid = last_valid_ff;
      sts.t_less     = (time_ff < rd_time_ff);
      sts.link_null  = (rd_link_ff >= NULL_LINK);
      sts.k_hit      = (k_ff == {1'b0, rank_ff});
      sts.at_head    = at_head_ff;
      sts.sweep_last = (sw_addr_ff == AW'(DEPTH - 1));
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_time_out = rsp_time_ff;
   assign rsp_name_out = rsp_name_ff;

   `SLT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `SLT_ASSERT_NOW(a_error_no_data, clock, reset,
                   rsp_strobe_ff && (rsp_status_ff != ST_OK),
                   (rsp_time_ff == 32'd0) && (rsp_name_ff == 64'd0))
   `SLT_ASSERT_NEXT(a_last_sticky, clock, reset, last_valid_ff, last_valid_ff)

endmodule

`default_nettype wire

// ----- tb/sorted_linked_table_top_tb.sv -----
`timescale 1ns / 1ps

module sorted_linked_table_top_tb;
   import slt_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int MODES      = 4;
   localparam int NAME_BYTES = 8;
   localparam int NULL_LINK  = ENTRIES;
   localparam int DRAIN_WAIT = MODES * ENTRIES + 40;
   localparam int WATCHDOG   = 4000;

   typedef struct packed {
      op_type      op;
      logic [1:0]  mode;
      logic [31:0] tval;
      logic [63:0] chars;
      logic [7:0]  nlen;
      logic [7:0]  rank;
   } request_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] tval;
      logic [63:0] chars;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_time_value = '0;
   logic [63:0] req_name_chars = '0;
   logic [7:0]  req_name_length = '0;
   logic [7:0]  req_rank_wanted = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_time_out;
   logic [63:0] rsp_name_out;

   sorted_linked_table_top #(
      .ENTRIES(ENTRIES), .MODES(MODES), .NAME_BYTES(NAME_BYTES)
   ) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_mode(req_mode),
      .req_time_value(req_time_value), .req_name_chars(req_name_chars),
      .req_name_length(req_name_length), .req_rank_wanted(req_rank_wanted),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_time_out(rsp_time_out), .rsp_name_out(rsp_name_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the table
   int          link_mem [MODES][ENTRIES];
   logic [31:0] time_mem [MODES][ENTRIES];
   logic [63:0] name_mem [MODES][ENTRIES];
   int          used_top [MODES];
   int          free_top [MODES];
   bit          last_ok;
   int          last_mode, last_entry;

   request_type pending_reqs[$];
   answer_type  expected_answers[$];
   int       mismatches = 0;
   int       answers_seen = 0;
   int       idle_cycles = 0;
   bit       timed_out = 1'b0;
   int       op_count [4];

   function automatic void relink_table();
      for (int m = 0; m < MODES; m++) begin
         used_top[m] = NULL_LINK;
         free_top[m] = 0;
         for (int i = 0; i < ENTRIES; i++) link_mem[m][i] = i + 1;
      end
   endfunction

   function automatic answer_type table_answer(request_type r);
      answer_type a;
      int m, slot, cur, nxt, idx;
      a = '{status: ST_OK, tval: '0, chars: '0};
      m = r.mode;
      case (r.op)
         OP_RECORD: begin
            if (m >= MODES) a.status = ST_FULL;
            else if (r.nlen > NAME_BYTES) a.status = ST_NAME_LONG;
            else if (free_top[m] >= ENTRIES) a.status = ST_FULL;
            else begin
               slot = free_top[m];
               free_top[m] = link_mem[m][slot];
               time_mem[m][slot] = r.tval;
               name_mem[m][slot] = (r.nlen >= 8) ? r.chars
                                 : r.chars & ((64'd1 << (8 * r.nlen)) - 1);
               last_ok = 1'b1;
               last_mode = m;
               last_entry = slot;
               cur = used_top[m];
               if (cur >= ENTRIES || r.tval < time_mem[m][cur]) begin
                  link_mem[m][slot] = cur;
                  used_top[m] = slot;
               end else begin
                  for (int s = 0; s < ENTRIES; s++) begin
                     nxt = link_mem[m][cur];
                     if (nxt >= ENTRIES || r.tval < time_mem[m][nxt]) break;
                     cur = nxt;
                  end
                  link_mem[m][slot] = link_mem[m][cur];
                  link_mem[m][cur] = slot;
               end
            end
         end
         OP_RANK: begin
            a.status = ST_RANK;
            if (m < MODES && r.rank != 0) begin
               idx = used_top[m];
               for (int k = 1; k <= ENTRIES && idx < ENTRIES; k++) begin
                  if (k == r.rank) begin
                     a = '{status: ST_OK, tval: time_mem[m][idx],
                           chars: name_mem[m][idx]};
                     break;
                  end
                  idx = link_mem[m][idx];
               end
            end
         end
         OP_CLEAR: relink_table();
         default: begin
            if (!last_ok) a.status = ST_NO_LAST;
            else a = '{status: ST_OK, tval: time_mem[last_mode][last_entry],
                       chars: name_mem[last_mode][last_entry]};
         end
      endcase
      return a;
   endfunction

   function automatic request_type make_req(op_type op, int mode, logic [31:0] t,
                                            logic [63:0] c, int nlen, int rank);
      request_type r;
      r = '{op: op, mode: mode[1:0], tval: t, chars: c, nlen: nlen[7:0],
            rank: rank[7:0]};
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // driver: bursts of transactions separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_answers.push_back(table_answer(pending_reqs.pop_front()));
         start <= 1'b0;
         if (burst_left > 0) burst_left <= burst_left - 1;
         else gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() != 0) begin
            r = pending_reqs[0];
            req_opcode      <= r.op;
            req_mode        <= r.mode;
            req_time_value  <= r.tval;
            req_name_chars  <= r.chars;
            req_name_length <= r.nlen;
            req_rank_wanted <= r.rank;
            start <= 1'b1;
            if (burst_left == 0) burst_left <= $urandom_range(0, 12);
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      answer_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected result status %0d", rsp_status);
            end else begin
               e = expected_answers.pop_front();
               if (rsp_status !== e.status || rsp_time_out !== e.tval
                   || rsp_name_out !== e.chars) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("mismatch: exp st %0d t %h n %h, got st %0d t %h n %h",
                              e.status, e.tval, e.chars,
                              rsp_status, rsp_time_out, rsp_name_out);
               end
            end
         end
      end
   end

   initial begin
      int m, kind;
      logic [31:0] t;
      relink_table();
      last_ok = 1'b0;
      last_mode = 0;
      last_entry = 0;
      for (int k = 0; k < 4; k++) op_count[k] = 0;

      // directed: no last record, empty ranks, extremes, full table, clear
      pending_reqs.push_back(make_req(OP_LAST, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_RANK, 0, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(OP_RECORD, 0, 32'hFFFF_FFFF, '1, 8, 0));
      pending_reqs.push_back(make_req(OP_RECORD, 0, 0, '1, 0, 0));
      pending_reqs.push_back(make_req(OP_RECORD, 0, 32'h8000_0000, '1, 3, 0));
      pending_reqs.push_back(make_req(OP_RECORD, 0, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 5, 0));
      pending_reqs.push_back(make_req(OP_RECORD, 1, 7, '1, 9, 0));
      pending_reqs.push_back(make_req(OP_RECORD, 1, 7, '1, 255, 0));
      pending_reqs.push_back(make_req(OP_RANK, 0, 0, 0, 0, 0));
      for (int r = 1; r <= 5; r++) pending_reqs.push_back(make_req(OP_RANK, 0, 0, 0, 0, r));
      pending_reqs.push_back(make_req(OP_RANK, 0, 0, 0, 0, 255));
      pending_reqs.push_back(make_req(OP_LAST, 0, 0, 0, 0, 0));
      for (int i = 0; i < 16; i++)
         pending_reqs.push_back(make_req(OP_RECORD, 3, $urandom_range(0, 20), rand64(), 8, 0));
      pending_reqs.push_back(make_req(OP_RECORD, 3, 5, rand64(), 8, 0));
      pending_reqs.push_back(make_req(OP_RANK, 3, 0, 0, 0, 16));
      pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_LAST, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_RANK, 3, 0, 0, 0, 1));

      // random: mostly records and rank fetches, occasional clears
      for (int i = 0; i < 750; i++) begin
         kind = $urandom_range(0, 99);
         m = $urandom_range(0, 3);
         t = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom();
         if (kind < 50)
            pending_reqs.push_back(make_req(OP_RECORD, m, t, rand64(),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8), 0));
         else if (kind < 85)
            pending_reqs.push_back(make_req(OP_RANK, m, $urandom(), rand64(),
               $urandom_range(0, 255),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 17)));
         else if (kind < 88)
            pending_reqs.push_back(make_req(OP_CLEAR, m, $urandom(), rand64(), 0, 0));
         else
            pending_reqs.push_back(make_req(OP_LAST, m, $urandom(), rand64(), 0, 0));
      end
      foreach (pending_reqs[i]) op_count[pending_reqs[i].op]++;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            while (pending_reqs.size() != 0 || start || expected_answers.size() != 0)
               @(posedge clock);
            repeat (DRAIN_WAIT) @(posedge clock);
         end
         begin
            wait (idle_cycles >= WATCHDOG);
            timed_out = 1'b1;
         end
      join_any

      if (timed_out) begin
         $display("[sorted_linked_table_top] ERROR");
         $finish;
      end else begin
         $display("covered %0d records, %0d rank fetches, %0d clears, %0d last fetches",
                  op_count[0], op_count[1], op_count[2], op_count[3]);
         $display("%0d results checked, %0d mismatches", answers_seen, mismatches);
         if (mismatches == 0 && expected_answers.size() == 0)
            $display("[sorted_linked_table_top] OK");
         else
            $display("[sorted_linked_table_top] ERROR");
         $finish;
      end
   end

endmodule
